@@ rtl/ppsd_pkg.sv @@
// shared types and constants for the pressure pid with steady detection
`default_nettype none
package ppsd_pkg;

    typedef logic [3:0] t_op;

    typedef struct packed {
        t_op  op;
        logic out_load;
    } t_cmd;

    // datapath step codes
    localparam t_op OP_NONE  = 4'd0;
    localparam t_op OP_LOAD  = 4'd1;
    localparam t_op OP_RECIP = 4'd2;
    localparam t_op OP_QEST  = 4'd3;
    localparam t_op OP_FIX   = 4'd4;
    localparam t_op OP_ERR   = 4'd5;
    localparam t_op OP_MKP   = 4'd6;
    localparam t_op OP_MKD   = 4'd7;
    localparam t_op OP_MKIL  = 4'd8;
    localparam t_op OP_MKIH  = 4'd9;
    localparam t_op OP_ISUM  = 4'd10;
    localparam t_op OP_PSUM  = 4'd11;
    localparam t_op OP_MSL   = 4'd12;
    localparam t_op OP_MSH   = 4'd13;
    localparam t_op OP_SPD   = 4'd14;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP        = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI        = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KD        = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 4'd7;

    // register reset values
    localparam logic [14:0] RST_SETPOINT  = 15'd0;
    localparam logic [15:0] RST_KP        = 16'd256;
    localparam logic [15:0] RST_KI        = 16'd0;
    localparam logic [15:0] RST_KD        = 16'd0;
    localparam logic [15:0] RST_SCALE     = 16'd256;
    localparam logic [15:0] RST_LIMIT     = 16'd1000;
    localparam logic [14:0] RST_THRESHOLD = 15'd256;
    localparam logic [15:0] RST_WINDOW    = 16'd1000;

    // full scale pressure in q8.8 kpa
    localparam logic [26:0] FULL_SCALE_Q88 = 27'd25600;
    localparam int          RECIP_SHIFT    = 27;

    // integral term and pid sum caps
    localparam logic signed [59:0] ITERM_CAP = 60'sh200_0000_0000;
    localparam logic signed [43:0] SUM_CAP   = 44'sh100_0000_0000;

endpackage
`default_nettype wire

@@ rtl/ppsd_ctrl.sv @@
// sequencer for the pressure pid: steps one sample through the shared multiplier
`default_nettype none
module ppsd_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output ppsd_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RECIP = 4'd1;
    localparam logic [3:0] ST_QEST  = 4'd2;
    localparam logic [3:0] ST_FIX   = 4'd3;
    localparam logic [3:0] ST_ERR   = 4'd4;
    localparam logic [3:0] ST_MKP   = 4'd5;
    localparam logic [3:0] ST_MKD   = 4'd6;
    localparam logic [3:0] ST_MKIL  = 4'd7;
    localparam logic [3:0] ST_MKIH  = 4'd8;
    localparam logic [3:0] ST_ISUM  = 4'd9;
    localparam logic [3:0] ST_PSUM  = 4'd10;
    localparam logic [3:0] ST_MSL   = 4'd11;
    localparam logic [3:0] ST_MSH   = 4'd12;
    localparam logic [3:0] ST_SPD   = 4'd13;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd.op       = ppsd_pkg::OP_NONE;
        o_cmd.out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = ppsd_pkg::OP_LOAD;
                    n_state  = ST_RECIP;
                end
            end
            ST_RECIP: begin
                o_cmd.op = ppsd_pkg::OP_RECIP;
                n_state  = ST_QEST;
            end
            ST_QEST: begin
                o_cmd.op = ppsd_pkg::OP_QEST;
                n_state  = ST_FIX;
            end
            ST_FIX: begin
                o_cmd.op = ppsd_pkg::OP_FIX;
                n_state  = ST_ERR;
            end
            ST_ERR: begin
                o_cmd.op = ppsd_pkg::OP_ERR;
                n_state  = ST_MKP;
            end
            ST_MKP: begin
                o_cmd.op = ppsd_pkg::OP_MKP;
                n_state  = ST_MKD;
            end
            ST_MKD: begin
                o_cmd.op = ppsd_pkg::OP_MKD;
                n_state  = ST_MKIL;
            end
            ST_MKIL: begin
                o_cmd.op = ppsd_pkg::OP_MKIL;
                n_state  = ST_MKIH;
            end
            ST_MKIH: begin
                o_cmd.op = ppsd_pkg::OP_MKIH;
                n_state  = ST_ISUM;
            end
            ST_ISUM: begin
                o_cmd.op = ppsd_pkg::OP_ISUM;
                n_state  = ST_PSUM;
            end
            ST_PSUM: begin
                o_cmd.op = ppsd_pkg::OP_PSUM;
                n_state  = ST_MSL;
            end
            ST_MSL: begin
                o_cmd.op = ppsd_pkg::OP_MSL;
                n_state  = ST_MSH;
            end
            ST_MSH: begin
                o_cmd.op = ppsd_pkg::OP_MSH;
                n_state  = ST_SPD;
            end
            ST_SPD: begin
                o_cmd.op = ppsd_pkg::OP_SPD;
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

@@ rtl/ppsd_datapath.sv @@
// datapath: configuration registers, loop state, shared multiplier and result register
`default_nettype none
module ppsd_datapath #(
    parameter int SAMPLE_MAX    = 4095,
    parameter int INTEGRAL_BITS = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  ppsd_pkg::t_cmd                      i_cmd,
    input  wire                                 i_cfg_we,
    input  wire  [ppsd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [15:0]                         i_cfg_data,
    input  wire  [11:0]                         i_raw_sample,
    input  wire  [31:0]                         i_now_ms,
    output logic [15:0]                         o_speed_command,
    output logic                                o_is_steady,
    output logic [14:0]                         o_pressure_kpa
);

    localparam int          RS    = ppsd_pkg::RECIP_SHIFT;
    localparam logic [20:0] RECIP = 21'((64'd1 << RS) / 64'(SAMPLE_MAX));
    localparam logic [27:0] DIV_D = 28'(SAMPLE_MAX);
    localparam int          IB    = INTEGRAL_BITS;

    // configuration
    logic [14:0] r_setpoint, r_thr;
    logic [15:0] r_kp, r_ki, r_kd, r_scale, r_limit, r_window;

    // loop state
    logic signed [IB-1:0] r_integ;
    logic signed [16:0]   r_prev;
    logic [47:0]          r_abs_sum;
    logic [31:0]          r_count;
    logic [31:0]          r_wstart;
    logic                 r_steady;

    // working registers
    logic [26:0]        r_x;
    logic [31:0]        r_now;
    logic [18:0]        r_q;
    logic signed [53:0] r_prod;
    logic [14:0]        r_press;
    logic signed [15:0] r_err;
    logic signed [16:0] r_deriv;
    logic signed [34:0] r_acc;
    logic [39:0]        r_lo;
    logic signed [42:0] r_iterm;
    logic [40:0]        r_sumc;
    logic               r_pos;
    logic [46:0]        r_thrp;

    // result register
    logic [15:0] r_speed;
    logic        r_steady_o;
    logic [14:0] r_kpa;

    logic signed [32:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [53:0] mul_p;
    logic               mul_en;

    logic [27:0]        rem;
    logic [18:0]        q_fix;
    logic signed [IB:0] integ_sum;
    logic signed [IB-1:0] n_integ;
    logic [14:0]        err_abs;
    logic [48:0]        abs_acc;
    logic signed [63:0] integ_ext;
    logic signed [42:0] ic;
    logic signed [59:0] iraw;
    logic signed [43:0] psum;
    logic [31:0]        elapsed;
    logic [33:0]        spd_full;
    logic [15:0]        spd;

    // sum scale and clamp pieces
    assign rem     = {1'b0, r_x} - r_prod[27:0];
    assign q_fix   = (rem >= DIV_D) ? r_q + 19'd1 : r_q;

    assign integ_sum = (IB+1)'(r_integ) + (IB+1)'(r_err);
    always_comb begin
        if (integ_sum[IB] != integ_sum[IB-1]) begin
            n_integ = integ_sum[IB] ? {1'b1, {(IB-1){1'b0}}} : {1'b0, {(IB-1){1'b1}}};
        end else begin
            n_integ = integ_sum[IB-1:0];
        end
    end

    assign err_abs = r_err[15] ? 15'(-r_err) : 15'(r_err);
    assign abs_acc = {1'b0, r_abs_sum} + 49'(err_abs);

    assign integ_ext = 64'(r_integ);
    always_comb begin
        if (integ_ext > 64'(ppsd_pkg::ITERM_CAP)) begin
            ic = 43'(ppsd_pkg::ITERM_CAP);
        end else if (integ_ext < -64'(ppsd_pkg::ITERM_CAP)) begin
            ic = -43'(ppsd_pkg::ITERM_CAP);
        end else begin
            ic = integ_ext[42:0];
        end
    end

    assign iraw = (60'(signed'(r_prod[34:0])) <<< 24) + 60'(r_lo);
    assign psum = 44'(r_acc) + 44'(r_iterm);
    assign elapsed  = r_now - r_wstart;
    assign spd_full = r_prod[33:0] + 34'(r_lo[39:24]);
    always_comb begin
        if (!r_pos) begin
            spd = 16'd0;
        end else if (spd_full > 34'(r_limit)) begin
            spd = r_limit;
        end else begin
            spd = spd_full[15:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (i_cmd.op)
            ppsd_pkg::OP_RECIP: begin
                mul_a = {6'd0, r_x};
                mul_b = RECIP;
            end
            ppsd_pkg::OP_QEST: begin
                mul_a = {14'd0, r_prod[45:27]};
                mul_b = DIV_D[20:0];
            end
            ppsd_pkg::OP_MKP: begin
                mul_a = 33'(r_err);
                mul_b = {5'd0, r_kp};
            end
            ppsd_pkg::OP_MKD: begin
                mul_a = 33'(r_deriv);
                mul_b = {5'd0, r_kd};
            end
            ppsd_pkg::OP_MKIL: begin
                mul_a = {9'd0, ic[23:0]};
                mul_b = {5'd0, r_ki};
            end
            ppsd_pkg::OP_MKIH: begin
                mul_a = 33'(signed'(ic[42:24]));
                mul_b = {5'd0, r_ki};
            end
            ppsd_pkg::OP_PSUM: begin
                mul_a = {1'b0, r_count};
                mul_b = {6'd0, r_thr};
            end
            ppsd_pkg::OP_MSL: begin
                mul_a = {9'd0, r_sumc[23:0]};
                mul_b = {5'd0, r_scale};
            end
            ppsd_pkg::OP_MSH: begin
                mul_a = {16'd0, r_sumc[40:24]};
                mul_b = {5'd0, r_scale};
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= ppsd_pkg::RST_SETPOINT;
            r_kp       <= ppsd_pkg::RST_KP;
            r_ki       <= ppsd_pkg::RST_KI;
            r_kd       <= ppsd_pkg::RST_KD;
            r_scale    <= ppsd_pkg::RST_SCALE;
            r_limit    <= ppsd_pkg::RST_LIMIT;
            r_thr      <= ppsd_pkg::RST_THRESHOLD;
            r_window   <= ppsd_pkg::RST_WINDOW;
            r_integ    <= '0;
            r_prev     <= '0;
            r_abs_sum  <= '0;
            r_count    <= '0;
            r_wstart   <= '0;
            r_steady   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ppsd_pkg::REG_SETPOINT:  r_setpoint <= i_cfg_data[14:0];
                    ppsd_pkg::REG_KP:        r_kp       <= i_cfg_data;
                    ppsd_pkg::REG_KI:        r_ki       <= i_cfg_data;
                    ppsd_pkg::REG_KD:        r_kd       <= i_cfg_data;
                    ppsd_pkg::REG_SCALE:     r_scale    <= i_cfg_data;
                    ppsd_pkg::REG_LIMIT:     r_limit    <= i_cfg_data;
                    ppsd_pkg::REG_THRESHOLD: r_thr      <= i_cfg_data[14:0];
                    ppsd_pkg::REG_WINDOW:    r_window   <= i_cfg_data;
                    default: ;
                endcase
            end
            case (i_cmd.op)
                ppsd_pkg::OP_MKP: begin
                    r_integ   <= n_integ;
                    r_prev    <= 17'(r_err);
                    r_abs_sum <= abs_acc[48] ? {48{1'b1}} : abs_acc[47:0];
                    if (r_count != {32{1'b1}}) begin
                        r_count <= r_count + 32'd1;
                    end
                end
                ppsd_pkg::OP_MSH: begin
                    if (elapsed >= 32'(r_window)) begin
                        r_steady  <= (r_abs_sum < 48'(r_thrp));
                        r_abs_sum <= '0;
                        r_count   <= '0;
                        r_wstart  <= r_now;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_p;
        end
        case (i_cmd.op)
            ppsd_pkg::OP_LOAD: begin
                r_x   <= 27'(i_raw_sample) * ppsd_pkg::FULL_SCALE_Q88;
                r_now <= i_now_ms;
            end
            ppsd_pkg::OP_QEST: r_q     <= r_prod[45:27];
            ppsd_pkg::OP_FIX:  r_press <= q_fix[14:0];
            ppsd_pkg::OP_ERR:  r_err   <= 16'({1'b0, r_setpoint}) - 16'({1'b0, r_press});
            ppsd_pkg::OP_MKP:  r_deriv <= 17'(r_err) - r_prev;
            ppsd_pkg::OP_MKD:  r_acc   <= r_prod[34:0];
            ppsd_pkg::OP_MKIL: r_acc   <= r_acc + r_prod[34:0];
            ppsd_pkg::OP_MKIH: r_lo    <= r_prod[39:0];
            ppsd_pkg::OP_ISUM: begin
                if (iraw > ppsd_pkg::ITERM_CAP) begin
                    r_iterm <= 43'(ppsd_pkg::ITERM_CAP);
                end else if (iraw < -ppsd_pkg::ITERM_CAP) begin
                    r_iterm <= -43'(ppsd_pkg::ITERM_CAP);
                end else begin
                    r_iterm <= iraw[42:0];
                end
            end
            ppsd_pkg::OP_PSUM: begin
                r_pos  <= (psum > 44'sd0);
                r_sumc <= (psum > ppsd_pkg::SUM_CAP) ? 41'(ppsd_pkg::SUM_CAP) : psum[40:0];
            end
            ppsd_pkg::OP_MSL:  r_thrp <= r_prod[46:0];
            ppsd_pkg::OP_MSH:  r_lo   <= r_prod[39:0];
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_speed    <= spd;
            r_steady_o <= r_steady;
            r_kpa      <= r_press;
        end
    end

    assign o_speed_command = r_speed;
    assign o_is_steady     = r_steady_o;
    assign o_pressure_kpa  = r_kpa;

endmodule
`default_nettype wire

@@ rtl/pressure_pid_with_steady_detect.sv @@
// top level: pressure pid controller with steady-state window detection
// each sample steps through the sequencer states in order; the spd state loads the result
// register once the earlier result is taken; a new sample is accepted only in idle, as the
//   sequencer steps the single shared 33x21 multiplier through nine products per sample
// the result register lets the next sample start while a result waits for transfer
// synchronous active-low reset restores register defaults and clears pid and window state
`default_nettype none
module pressure_pid_with_steady_detect #(
    parameter int SAMPLE_MAX    = 4095,
    parameter int INTEGRAL_BITS = 32
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [ppsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [15:0]                     i_cfg_data,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  [11:0]                     i_raw_sample,
    input  wire  [31:0]                     i_now_ms,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [15:0]                     o_speed_command,
    output logic                            o_is_steady,
    output logic [14:0]                     o_pressure_kpa
);

    ppsd_pkg::t_cmd cmd;

    ppsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    ppsd_datapath #(
        .SAMPLE_MAX    (SAMPLE_MAX),
        .INTEGRAL_BITS (INTEGRAL_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_raw_sample    (i_raw_sample),
        .i_now_ms        (i_now_ms),
        .o_speed_command (o_speed_command),
        .o_is_steady     (o_is_steady),
        .o_pressure_kpa  (o_pressure_kpa)
    );

endmodule
`default_nettype wire
